FILE: hdl/assert_macros.svh
// Assertion macros used by the MIDI parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MRSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define MRSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/mrsp_pkg.sv
// Package: constants, types and helpers of the MIDI running status parser.
`default_nettype none

package mrsp_pkg;

  localparam int unsigned PortWidth = 4;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned DataWidth = 7;
  localparam int unsigned CountWidth = 2;

  localparam logic [PortWidth-1:0] PortReset = 4'h0;

  localparam logic [ByteWidth-1:0] RealtimeMin = 8'hF8;
  localparam logic [ByteWidth-1:0] SysexEnd = 8'hF7;
  localparam logic [ByteWidth-1:0] SysexStart = 8'hF0;
  localparam logic [ByteWidth-1:0] NoStatus = 8'h00;
  localparam logic [ByteWidth-1:0] SongPosition = 8'hF2;
  localparam logic [ByteWidth-1:0] TimeCode = 8'hF1;
  localparam logic [ByteWidth-1:0] SongSelect = 8'hF3;
  localparam logic [3:0] ProgramChange = 4'hC;
  localparam logic [3:0] ChannelPressure = 4'hD;
  localparam logic [3:0] SystemNibble = 4'hF;

  localparam logic [CountWidth-1:0] CountZero = 2'd0;
  localparam logic [CountWidth-1:0] CountOne = 2'd1;
  localparam logic [CountWidth-1:0] CountTwo = 2'd2;

  typedef struct packed {
    logic [PortWidth-1:0] source_port;
    logic [ByteWidth-1:0] status_byte;
    logic [3:0]           channel;
    logic [DataWidth-1:0] data_one;
    logic [DataWidth-1:0] data_two;
  } msg_t;

  typedef struct packed {
    logic [ByteWidth-1:0]  running_status;
    logic [DataWidth-1:0]  first_data;
    logic [CountWidth-1:0] collected_count;
    logic [CountWidth-1:0] expected_count;
    logic                  in_sysex;
  } parse_state_t;

  function automatic logic [CountWidth-1:0] data_count(input logic [ByteWidth-1:0] s);
    logic [CountWidth-1:0] cnt;
    if (s[7:4] == SystemNibble) begin
      if (s == SongPosition) begin
        cnt = CountTwo;
      end else if (s == TimeCode || s == SongSelect) begin
        cnt = CountOne;
      end else begin
        cnt = CountZero;
      end
    end else if (s[7:4] == ProgramChange || s[7:4] == ChannelPressure) begin
      cnt = CountOne;
    end else begin
      cnt = CountTwo;
    end
    return cnt;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mrsp_byte_if.sv
// Interface: input channel carrying one raw MIDI byte per word.
`default_nettype none

interface mrsp_byte_if;
  logic                           valid;
  logic                           ready;
  logic [mrsp_pkg::ByteWidth-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/mrsp_msg_if.sv
// Interface: output channel carrying one decoded MIDI message per word.
`default_nettype none

interface mrsp_msg_if;
  logic                           valid;
  logic                           ready;
  logic [mrsp_pkg::PortWidth-1:0] source_port;
  logic [mrsp_pkg::ByteWidth-1:0] status_byte;
  logic [3:0]                     channel;
  logic [mrsp_pkg::DataWidth-1:0] data_one;
  logic [mrsp_pkg::DataWidth-1:0] data_two;

  modport source (output valid, output source_port, output status_byte, output channel,
                  output data_one, output data_two, input ready);
  modport sink (input valid, input source_port, input status_byte, input channel,
                input data_one, input data_two, output ready);
endinterface

`default_nettype wire

FILE: hdl/mrsp_in_stage.sv
// Input register: holds one received byte until the decoder takes it.
`default_nettype none

module mrsp_in_stage (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  mrsp_byte_if.sink                           in_i,
  input  wire logic                           advance_i,
  output logic                                valid_o,
  output logic [mrsp_pkg::ByteWidth-1:0]      byte_o
);

  logic                           valid_q, valid_d;
  logic [mrsp_pkg::ByteWidth-1:0] byte_q;
  logic                           accept;

  assign in_i.ready = !valid_q || advance_i;
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= in_i.in_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o = byte_q;

endmodule

`default_nettype wire

FILE: hdl/mrsp_decoder.sv
// Decoder: running status state and the per-byte message decode.
`default_nettype none

`include "assert_macros.svh"

module mrsp_decoder (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           advance_i,
  input  wire logic [mrsp_pkg::ByteWidth-1:0] byte_i,
  input  wire logic [mrsp_pkg::PortWidth-1:0] port_i,
  output logic                                emit_o,
  output mrsp_pkg::msg_t                      msg_o
);

  mrsp_pkg::parse_state_t state_q, state_d;
  logic [mrsp_pkg::CountWidth-1:0] new_count;

  assign new_count = mrsp_pkg::data_count(byte_i);

  always_comb begin
    state_d = state_q;
    emit_o = 1'b0;
    msg_o.source_port = port_i;
    msg_o.status_byte = byte_i;
    msg_o.channel = 4'h0;
    msg_o.data_one = '0;
    msg_o.data_two = '0;
    if (byte_i >= mrsp_pkg::RealtimeMin) begin
      emit_o = 1'b1;
    end else if (byte_i == mrsp_pkg::SysexEnd) begin
      state_d.in_sysex = 1'b0;
    end else if (state_q.in_sysex) begin
      // drop everything inside SysEx
    end else if (byte_i == mrsp_pkg::SysexStart) begin
      state_d.in_sysex = 1'b1;
      state_d.running_status = mrsp_pkg::NoStatus;
    end else if (byte_i[7]) begin
      state_d.running_status = byte_i;
      state_d.collected_count = mrsp_pkg::CountZero;
      state_d.expected_count = new_count;
      emit_o = (new_count == mrsp_pkg::CountZero);
    end else if (state_q.running_status == mrsp_pkg::NoStatus ||
                 state_q.expected_count == mrsp_pkg::CountZero) begin
      // drop stray data
    end else if (state_q.collected_count == mrsp_pkg::CountZero &&
                 state_q.expected_count == mrsp_pkg::CountTwo) begin
      state_d.first_data = byte_i[mrsp_pkg::DataWidth-1:0];
      state_d.collected_count = mrsp_pkg::CountOne;
    end else begin
      emit_o = 1'b1;
      msg_o.status_byte = state_q.running_status;
      msg_o.channel = state_q.running_status[3:0];
      if (state_q.expected_count == mrsp_pkg::CountTwo) begin
        msg_o.data_one = state_q.first_data;
        msg_o.data_two = byte_i[mrsp_pkg::DataWidth-1:0];
      end else begin
        msg_o.data_one = byte_i[mrsp_pkg::DataWidth-1:0];
      end
      state_d.collected_count = mrsp_pkg::CountZero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  `MRSP_ASSERT(a_collected_bound, state_q.collected_count <= mrsp_pkg::CountOne,
               "collected count above one")
  `MRSP_ASSERT_IMP(a_collected_needs_two, state_q.collected_count != mrsp_pkg::CountZero,
                   state_q.expected_count == mrsp_pkg::CountTwo,
                   "first data held for a message without two data bytes")
  `MRSP_ASSERT_IMP(a_sysex_no_status, state_q.in_sysex,
                   state_q.running_status == mrsp_pkg::NoStatus,
                   "running status set inside SysEx")
  `MRSP_ASSERT_IMP(a_status_msb, state_q.running_status != mrsp_pkg::NoStatus,
                   state_q.running_status[7], "running status is not a status byte")

endmodule

`default_nettype wire

FILE: hdl/mrsp_out_stage.sv
// Result register: holds one decoded message until the sink takes it.
`default_nettype none

module mrsp_out_stage (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire mrsp_pkg::msg_t msg_i,
  output logic                ready_o,
  mrsp_msg_if.source          out_o
);

  logic           valid_q, valid_d;
  mrsp_pkg::msg_t msg_q;

  assign ready_o = !valid_q || out_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      msg_q <= msg_i;
    end
  end

  assign out_o.valid = valid_q;
  assign out_o.source_port = msg_q.source_port;
  assign out_o.status_byte = msg_q.status_byte;
  assign out_o.channel = msg_q.channel;
  assign out_o.data_one = msg_q.data_one;
  assign out_o.data_two = msg_q.data_two;

endmodule

`default_nettype wire

FILE: hdl/midi_running_status_parser.sv
// Top level: MIDI byte stream parser with running status.
`default_nettype none

// Takes one MIDI byte per word on in_i and gives at most one decoded message per byte on
// out_o. A new byte is taken every cycle while out_o does not hold off a message; each
// message passes through the input register, the single decode step and the result
// register to out_o. Realtime bytes come out at once even inside other messages or SysEx;
// bytes inside SysEx are dropped, as is data with no usable running status. cfg_wdata_i
// sets the port number copied into every message and is written when cfg_we_i is high;
// the user must write it only with the block idle, which the block does not enforce.
module midi_running_status_parser (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mrsp_pkg::PortWidth-1:0] cfg_wdata_i,
  mrsp_byte_if.sink                           in_i,
  mrsp_msg_if.source                          out_o
);

  logic [mrsp_pkg::PortWidth-1:0] port_q;
  logic                           s1_valid;
  logic [mrsp_pkg::ByteWidth-1:0] s1_byte;
  logic                           s1_advance;
  logic                           emit;
  logic                           out_ready;
  mrsp_pkg::msg_t                 msg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q <= mrsp_pkg::PortReset;
    end else if (cfg_we_i) begin
      port_q <= cfg_wdata_i;
    end
  end

  assign s1_advance = s1_valid && (!emit || out_ready);

  mrsp_in_stage u_in_stage (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .advance_i(s1_advance),
    .valid_o  (s1_valid),
    .byte_o   (s1_byte)
  );

  mrsp_decoder u_decoder (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(s1_advance),
    .byte_i   (s1_byte),
    .port_i   (port_q),
    .emit_o   (emit),
    .msg_o    (msg)
  );

  mrsp_out_stage u_out_stage (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (s1_advance && emit),
    .msg_i  (msg),
    .ready_o(out_ready),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

FILE: test/midi_running_status_parser_tb.sv
`timescale 1ns / 100ps
// Testbench: random and directed MIDI byte streams into the parser, every message checked.
module midi_running_status_parser_tb;

  localparam int unsigned ClkHalf = 5;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned ReportLimit = 10;

  localparam logic [3:0] NoteOff = 4'h8;
  localparam logic [3:0] NoteOn = 4'h9;
  localparam logic [mrsp_pkg::ByteWidth-1:0] UndefCommon = 8'hF4;
  localparam logic [mrsp_pkg::ByteWidth-1:0] SystemReset = 8'hFF;
  localparam logic [mrsp_pkg::ByteWidth-1:0] ChannelMin = 8'h80;
  localparam logic [mrsp_pkg::ByteWidth-1:0] ChannelMax = 8'hEF;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i;
  logic [mrsp_pkg::PortWidth-1:0] cfg_wdata_i;

  mrsp_byte_if byte_ch ();
  mrsp_msg_if  msg_ch ();

  midi_running_status_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (byte_ch),
    .out_o       (msg_ch)
  );

  // Parser state as the checker sees it.
  logic [mrsp_pkg::PortWidth-1:0]  port_q = mrsp_pkg::PortReset;
  logic [mrsp_pkg::ByteWidth-1:0]  status_q = mrsp_pkg::NoStatus;
  logic [mrsp_pkg::DataWidth-1:0]  held_data = '0;
  logic [mrsp_pkg::CountWidth-1:0] got_count = mrsp_pkg::CountZero;
  logic [mrsp_pkg::CountWidth-1:0] need_count = mrsp_pkg::CountZero;
  logic                            sysex_on = 1'b0;
  mrsp_pkg::msg_t                  expected_msgs [$];

  int unsigned fail_count = 0;
  int unsigned bytes_used = 0;
  int unsigned idle_cycles = 0;
  bit          in_burst = 1'b0;
  bit          out_burst = 1'b0;
  bit          hold_request = 1'b0;

  always #ClkHalf clk_i = ~clk_i;

  function automatic void queue_msg(input mrsp_pkg::msg_t m);
    expected_msgs = {expected_msgs, m};
  endfunction

  // Advance the parser state by one byte; returns whether the byte was acted on.
  function automatic bit decode_byte(input logic [mrsp_pkg::ByteWidth-1:0] b);
    mrsp_pkg::msg_t                  m;
    logic [mrsp_pkg::CountWidth-1:0] need;
    bit                              used;
    m = '0;
    m.source_port = port_q;
    if (b >= mrsp_pkg::RealtimeMin) begin
      m.status_byte = b;
      queue_msg(m);
      return 1'b1;
    end
    if (b == mrsp_pkg::SysexEnd) begin
      used = sysex_on;
      sysex_on = 1'b0;
      return used;
    end
    if (sysex_on) return 1'b0;
    if (b == mrsp_pkg::SysexStart) begin
      sysex_on = 1'b1;
      status_q = mrsp_pkg::NoStatus;
      return 1'b1;
    end
    if (b[7]) begin
      status_q = b;
      got_count = mrsp_pkg::CountZero;
      if (b[7:4] == mrsp_pkg::SystemNibble) begin
        if (b == mrsp_pkg::SongPosition) need = mrsp_pkg::CountTwo;
        else if (b == mrsp_pkg::TimeCode || b == mrsp_pkg::SongSelect) need = mrsp_pkg::CountOne;
        else need = mrsp_pkg::CountZero;
      end else if (b[7:4] == mrsp_pkg::ProgramChange ||
                   b[7:4] == mrsp_pkg::ChannelPressure) begin
        need = mrsp_pkg::CountOne;
      end else begin
        need = mrsp_pkg::CountTwo;
      end
      need_count = need;
      if (need == mrsp_pkg::CountZero) begin
        m.status_byte = b;
        queue_msg(m);
      end
      return 1'b1;
    end
    if (status_q == mrsp_pkg::NoStatus || need_count == mrsp_pkg::CountZero) return 1'b0;
    if (got_count == mrsp_pkg::CountZero && need_count == mrsp_pkg::CountTwo) begin
      held_data = b[mrsp_pkg::DataWidth-1:0];
      got_count = mrsp_pkg::CountOne;
      return 1'b1;
    end
    m.status_byte = status_q;
    m.channel = status_q[3:0];
    if (need_count == mrsp_pkg::CountTwo) begin
      m.data_one = held_data;
      m.data_two = b[mrsp_pkg::DataWidth-1:0];
    end else begin
      m.data_one = b[mrsp_pkg::DataWidth-1:0];
    end
    got_count = mrsp_pkg::CountZero;
    queue_msg(m);
    return 1'b1;
  endfunction

  function automatic void report_failure(input string what, input mrsp_pkg::msg_t want,
                                         input mrsp_pkg::msg_t seen);
    if (fail_count < ReportLimit)
      $display("%0t %s: expected port %0h status %02h channel %0h data %02h %02h",
               $time, what, want.source_port, want.status_byte, want.channel,
               want.data_one, want.data_two);
    if (fail_count < ReportLimit)
      $display("    got port %0h status %02h channel %0h data %02h %02h",
               seen.source_port, seen.status_byte, seen.channel, seen.data_one, seen.data_two);
    fail_count++;
  endfunction

  always @(posedge clk_i) begin : monitor
    mrsp_pkg::msg_t seen;
    mrsp_pkg::msg_t want;
    idle_cycles++;
    if (rst_ni) begin
      if (cfg_we_i) port_q = cfg_wdata_i;
      if (byte_ch.valid && byte_ch.ready) begin
        idle_cycles = 0;
        if (decode_byte(byte_ch.in_byte)) bytes_used++;
      end
      if (msg_ch.valid && msg_ch.ready) begin
        idle_cycles = 0;
        seen.source_port = msg_ch.source_port;
        seen.status_byte = msg_ch.status_byte;
        seen.channel = msg_ch.channel;
        seen.data_one = msg_ch.data_one;
        seen.data_two = msg_ch.data_two;
        if (expected_msgs.size() == 0) begin
          report_failure("unexpected message", '0, seen);
        end else begin
          want = expected_msgs.pop_front();
          if (seen.source_port !== want.source_port || seen.status_byte !== want.status_byte ||
              seen.channel !== want.channel || seen.data_one !== want.data_one ||
              seen.data_two !== want.data_two)
            report_failure("message mismatch", want, seen);
        end
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= StallLimit);
    $display("midi_running_status_parser_tb failed");
    $finish;
  end

  initial begin : msg_receiver
    int unsigned stall;
    msg_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        msg_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      stall = out_burst ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        msg_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      msg_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!msg_ch.valid) @(posedge clk_i);
    end
  end

  task automatic send_byte(input logic [mrsp_pkg::ByteWidth-1:0] b);
    int unsigned gap;
    gap = in_burst ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_ch.valid <= 1'b1;
    byte_ch.in_byte <= b;
    @(posedge clk_i);
    while (!byte_ch.ready) @(posedge clk_i);
  endtask

  // Occasionally slip a realtime byte in ahead of the word.
  task automatic send_mixed(input logic [mrsp_pkg::ByteWidth-1:0] b);
    if ($urandom_range(0, 9) == 0)
      send_byte(8'($urandom_range(mrsp_pkg::RealtimeMin, SystemReset)));
    send_byte(b);
  endtask

  function automatic logic [mrsp_pkg::ByteWidth-1:0] random_data();
    return {1'b0, 7'($urandom)};
  endfunction

  task automatic set_port(input logic [mrsp_pkg::PortWidth-1:0] p);
    byte_ch.valid <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= p;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_phrase();
    logic [mrsp_pkg::ByteWidth-1:0] st;
    int unsigned                    n;
    int unsigned                    reps;
    int unsigned                    kind;
    kind = $urandom_range(0, 19);
    if (kind <= 8) begin
      st = 8'($urandom_range(ChannelMin, ChannelMax));
      n = (st[7:4] == mrsp_pkg::ProgramChange || st[7:4] == mrsp_pkg::ChannelPressure) ? 1 : 2;
      reps = $urandom_range(1, 4);
      send_mixed(st);
      repeat (reps * n) send_mixed(random_data());
    end else if (kind <= 10) begin
      case ($urandom_range(0, 3))
        0: begin
          st = mrsp_pkg::TimeCode;
          n = 1;
        end
        1: begin
          st = mrsp_pkg::SongPosition;
          n = 2;
        end
        2: begin
          st = mrsp_pkg::SongSelect;
          n = 1;
        end
        default: begin
          st = {mrsp_pkg::SystemNibble, 4'($urandom_range(4, 6))};
          n = 0;
        end
      endcase
      send_mixed(st);
      repeat (n) send_mixed(random_data());
      if (n == 0 && $urandom_range(0, 1) == 1) send_mixed(random_data());
    end else if (kind <= 12) begin
      send_mixed(mrsp_pkg::SysexStart);
      reps = $urandom_range(0, 8);
      repeat (reps) send_mixed(($urandom_range(0, 3) == 0) ? 8'($urandom) : random_data());
      send_mixed(mrsp_pkg::SysexEnd);
    end else if (kind <= 14) begin
      send_mixed(8'($urandom_range(ChannelMin, ChannelMax)));
      if ($urandom_range(0, 1) == 1) send_mixed(random_data());
    end else if (kind <= 16) begin
      reps = $urandom_range(1, 4);
      repeat (reps) send_byte(8'($urandom));
    end else if (kind == 17) begin
      send_byte(random_data());
    end else begin
      reps = $urandom_range(1, 3);
      repeat (reps) send_byte(8'($urandom_range(mrsp_pkg::RealtimeMin, SystemReset)));
    end
  endtask

  task automatic test_directed_stream();
    logic [mrsp_pkg::ByteWidth-1:0] stream [27] = '{
      8'h45, mrsp_pkg::SysexEnd, {NoteOff, 4'h0}, 8'h00, 8'h7F, 8'h12, mrsp_pkg::RealtimeMin,
      8'h34, {mrsp_pkg::ProgramChange, 4'hF}, 8'h7F, UndefCommon, 8'h22, mrsp_pkg::SysexStart,
      {NoteOn, 4'hA}, mrsp_pkg::SysexStart, SystemReset, mrsp_pkg::SysexEnd, 8'h33,
      mrsp_pkg::TimeCode, 8'h0A, mrsp_pkg::SongPosition, 8'h01, 8'h02, mrsp_pkg::SongSelect,
      8'h05, {mrsp_pkg::ChannelPressure, 4'h5}, 8'h40};
    foreach (stream[i]) send_byte(stream[i]);
  endtask

  task automatic test_random_phrases(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_used + count;
    while (bytes_used < stop_at) begin
      if ($urandom_range(0, 31) == 0) in_burst = ~in_burst;
      if ($urandom_range(0, 31) == 0) out_burst = ~out_burst;
      send_phrase();
    end
    in_burst = 1'b0;
    out_burst = 1'b0;
  endtask

  task automatic test_port_settings();
    logic [mrsp_pkg::PortWidth-1:0] ports [3];
    ports[0] = 4'hF;
    ports[1] = 4'($urandom_range(1, 14));
    ports[2] = mrsp_pkg::PortReset;
    foreach (ports[i]) begin
      set_port(ports[i]);
      test_random_phrases(120);
    end
  endtask

  // Hold the output off while words keep coming, so the input stalls.
  task automatic test_output_backpressure();
    int unsigned k;
    in_burst = 1'b1;
    hold_request = 1'b1;
    for (k = 0; k < 40; k++) begin
      send_byte(8'($urandom_range(mrsp_pkg::RealtimeMin, SystemReset)));
      send_byte({NoteOn, 4'(k)});
      send_byte(random_data());
      send_byte(random_data());
    end
    in_burst = 1'b0;
  endtask

  initial begin
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= mrsp_pkg::PortReset;
    byte_ch.valid <= 1'b0;
    byte_ch.in_byte <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_stream();
    test_port_settings();
    test_output_backpressure();
    test_random_phrases(1000);

    byte_ch.valid <= 1'b0;
    while (expected_msgs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("midi_running_status_parser_tb passed");
    end else begin
      $display("midi_running_status_parser_tb failed");
    end
    $finish;
  end

endmodule
